/* hdl/tri3_pkg.sv */
// Shared widths and payload types for the 3D triangle area unit.
`default_nettype none

package tri3_pkg;

	// Input coordinate and intermediate widths
	localparam int COORD_W = 16;
	localparam int EDGE_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W - 1;
	localparam int HALF_W  = MAG_W / 2;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;

	// Square root chain: one root bit per cell
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 2;

	// Result width
	localparam int AREA_W  = 33;

	// Cross product magnitudes, one per axis (x, y, z)
	typedef logic [2:0][MAG_W-1:0] tri3_vec_t;

	// Payload handed from one root cell to the next
	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} tri3_sqrt_t;

endpackage

`default_nettype wire

/* hdl/tri3_cross.sv */
// Edge vectors, cross product and component magnitudes (four stages).
`default_nettype none

module tri3_cross (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] ax,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] ay,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] az,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] bx,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] by,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] bz,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] cx,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] cy,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] cz,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output tri3_pkg::tri3_vec_t                 mag
);
	import tri3_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [EDGE_W-1:0]  e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PROD_W-1:0]  yz_s2, zy_s2, zx_s2, xz_s2, xy_s2, yx_s2;
	logic signed [CROSS_W-1:0] px_s3, py_s3, pz_s3;
	tri3_vec_t                 mag_s4;

	// A stage takes a new item when empty or when its item moves on
	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// Stage 1: edges relative to the third vertex
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			e1x_s1 <= EDGE_W'(ax) - EDGE_W'(cx);
			e1y_s1 <= EDGE_W'(ay) - EDGE_W'(cy);
			e1z_s1 <= EDGE_W'(az) - EDGE_W'(cz);
			e2x_s1 <= EDGE_W'(bx) - EDGE_W'(cx);
			e2y_s1 <= EDGE_W'(by) - EDGE_W'(cy);
			e2z_s1 <= EDGE_W'(bz) - EDGE_W'(cz);
		end
	end

	// Stage 2: the six signed products
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			yz_s2 <= e1y_s1 * e2z_s1;
			zy_s2 <= e1z_s1 * e2y_s1;
			zx_s2 <= e1z_s1 * e2x_s1;
			xz_s2 <= e1x_s1 * e2z_s1;
			xy_s2 <= e1x_s1 * e2y_s1;
			yx_s2 <= e1y_s1 * e2x_s1;
		end
	end

	// Stage 3: cross product components
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			px_s3 <= CROSS_W'(yz_s2) - CROSS_W'(zy_s2);
			py_s3 <= CROSS_W'(zx_s2) - CROSS_W'(xz_s2);
			pz_s3 <= CROSS_W'(xy_s2) - CROSS_W'(yx_s2);
		end
	end

	// Stage 4: magnitudes; the sign is lost when squaring anyway
	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			mag_s4[0] <= px_s3[CROSS_W-1] ? MAG_W'(-px_s3) : MAG_W'(px_s3);
			mag_s4[1] <= py_s3[CROSS_W-1] ? MAG_W'(-py_s3) : MAG_W'(py_s3);
			mag_s4[2] <= pz_s3[CROSS_W-1] ? MAG_W'(-pz_s3) : MAG_W'(pz_s3);
		end
	end

	assign out_valid = vld_s4;
	assign mag       = mag_s4;

endmodule

`default_nettype wire

/* hdl/tri3_sumsq.sv */
// Exact sum of squared magnitudes, split into half-width partial products.
`default_nettype none

module tri3_sumsq (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  tri3_pkg::tri3_vec_t            mag,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [tri3_pkg::SUM_W-1:0]     sum
);
	import tri3_pkg::*;

	logic vld_s5, vld_s6, vld_s7;
	logic rdy_s5, rdy_s6, rdy_s7;

	logic [2:0][2*HALF_W-1:0] hh_s5, hl_s5, ll_s5;
	logic [2:0][SQ_W-1:0]     sq_s6;
	logic [SUM_W-1:0]         sum_s7;

	assign rdy_s7   = !vld_s7 || out_ready;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s5) vld_s5 <= in_valid;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
		end
	end

	// Stage 5: high*high, high*low, low*low halves of each magnitude
	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= mag[i][MAG_W-1:HALF_W] * mag[i][MAG_W-1:HALF_W];
				hl_s5[i] <= mag[i][MAG_W-1:HALF_W] * mag[i][HALF_W-1:0];
				ll_s5[i] <= mag[i][HALF_W-1:0] * mag[i][HALF_W-1:0];
			end
		end
	end

	// Stage 6: recombine each square; the cross term counts twice
	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= {hh_s5[i], (2*HALF_W)'(0)}
					+ SQ_W'({hl_s5[i], (HALF_W+1)'(0)})
					+ SQ_W'(ll_s5[i]);
			end
		end
	end

	// Stage 7: sum of the three squares
	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			sum_s7 <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
		end
	end

	assign out_valid = vld_s7;
	assign sum       = sum_s7;

endmodule

`default_nettype wire

/* hdl/tri3_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per item.
`default_nettype none

module tri3_sqrt_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  tri3_pkg::tri3_sqrt_t  in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output tri3_pkg::tri3_sqrt_t  out_data
);
	import tri3_pkg::*;

	logic             valid_q;
	tri3_sqrt_t       data_q;
	logic [REM_W-1:0] cur;
	logic [REM_W-1:0] trial;
	logic [REM_W:0]   diff;
	logic             take;

	assign in_ready = !valid_q || out_ready;

	// Bring down two radicand bits and try root*4 + 1
	assign cur   = {in_data.rem[REM_W-3:0], in_data.rad[SUM_W-1 -: 2]};
	assign trial = {in_data.root, 2'b01};
	assign diff  = {1'b0, cur} - {1'b0, trial};
	assign take  = !diff[REM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q.rad  <= {in_data.rad[SUM_W-3:0], 2'b00};
			data_q.rem  <= take ? diff[REM_W-1:0] : cur;
			data_q.root <= {in_data.root[ROOT_W-2:0], take};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

/* hdl/triangle_area_3d_unit.sv */
// Top level: 3D triangle area from three vertices, unsigned integer out (no fraction bits).
// Stages: 4 cross-product, 3 sum-of-squares, 35 root cells at one root bit each.
// Throughput: one item per cycle unless out_ready stalls it; every stage
// holds its own item and takes a new one as soon as its current one moves on.
// Reset clears only the valid flags of the stages; data registers are not reset.
`default_nettype none

module triangle_area_3d_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] ax,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] ay,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] az,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] bx,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] by,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] bz,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] cx,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] cy,
	input  wire logic signed [tri3_pkg::COORD_W-1:0] cz,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [tri3_pkg::AREA_W-1:0]         area
);
	import tri3_pkg::*;

	logic             mag_valid, mag_ready;
	tri3_vec_t        mag;
	logic             sum_valid;
	logic [SUM_W-1:0] sum;

	logic [ROOT_W:0]  chain_valid;
	logic [ROOT_W:0]  chain_ready;
	tri3_sqrt_t       chain_data [ROOT_W+1];

	// Cross product and magnitudes
	tri3_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ax        (ax),
		.ay        (ay),
		.az        (az),
		.bx        (bx),
		.by        (by),
		.bz        (bz),
		.cx        (cx),
		.cy        (cy),
		.cz        (cz),
		.out_valid (mag_valid),
		.out_ready (mag_ready),
		.mag       (mag)
	);

	// Squared length of the cross product
	tri3_sumsq u_sumsq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mag_valid),
		.in_ready  (mag_ready),
		.mag       (mag),
		.out_valid (sum_valid),
		.out_ready (chain_ready[0]),
		.sum       (sum)
	);

	// Chain head: full radicand, empty remainder and root
	assign chain_valid[0]     = sum_valid;
	assign chain_data[0].rad  = sum;
	assign chain_data[0].rem  = '0;
	assign chain_data[0].root = '0;

	// Floor square root, one bit per cell, most significant first
	for (genvar i = 0; i < ROOT_W; i++) begin : g_root
		tri3_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	// Last cell is the output register; halving drops the root's low bit
	assign chain_ready[ROOT_W] = out_ready;
	assign out_valid           = chain_valid[ROOT_W];
	assign area                = chain_data[ROOT_W].root[AREA_W:1];

endmodule

`default_nettype wire
